[rtl/modified_utf8_string_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modified UTF-8 string decoder
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_UTF8_STRING_DECODER_ASSERT_SVH
`define MODIFIED_UTF8_STRING_DECODER_ASSERT_SVH

// Same-cycle implication
`define MU8SD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MU8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mu8sd_pkg.sv]
// ----------------------------------------------------------------------------
// mu8sd_pkg
// Constants and types for the modified UTF-8 string decoder.
// ----------------------------------------------------------------------------
package mu8sd_pkg;

    // Prefix counter value that marks the body phase
    localparam logic [2:0] BODY_PHASE  = 3'd7;
    localparam logic [2:0] PLEN_NARROW = 3'd2;
    localparam logic [2:0] PLEN_WIDE   = 3'd4;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Pending continuation byte counts
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_ONE  = 2'd1;
    localparam logic [1:0] SEQ_TWO  = 2'd2;

    // Register map
    localparam int         APB_ADDR_W      = 3;
    localparam int         APB_DATA_W      = 32;
    localparam logic [0:0] REG_PREFIX_WIDE = 1'b0;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_char;
        logic        last;
        logic        error;
    } result_t;

endpackage

[rtl/modified_utf8_string_decoder.sv]
// ----------------------------------------------------------------------------
// modified_utf8_string_decoder: length-prefixed modified UTF-8 to 16-bit units
// One byte per cycle when the output register is empty or drains (m_ready);
// a result appears the cycle after its byte in the single output register.
// Synchronous active-low reset clears string state, prefix_wide and m_valid.
// ----------------------------------------------------------------------------
module modified_utf8_string_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // byte stream
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_in_byte,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [15:0]                        m_code_unit,
    output logic                               m_has_char,
    output logic                               m_last,
    output logic                               m_error,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mu8sd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mu8sd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mu8sd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import mu8sd_pkg::*;

    `include "modified_utf8_string_decoder_assert.svh"

    logic        prefix_wide_reg;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic [15:0] body_remaining_reg, body_remaining_next;
    logic [1:0]  seq_pending_reg, seq_pending_next;
    logic [15:0] partial_unit_reg, partial_unit_next;
    logic        error_seen_reg, error_seen_next;

    logic        m_valid_reg, m_valid_next;
    result_t     result_reg, result_next;

    logic        in_accept;
    logic        res_valid;
    result_t     res;
    logic [2:0]  plen;
    logic [2:0]  count_inc;
    logic [15:0] len_shift;
    logic [15:0] rem_dec;
    logic [15:0] unit;
    logic        have_unit;
    logic        cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_PREFIX_WIDE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_wide_reg <= 1'b0;
        end else if (cfg_write) begin
            prefix_wide_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_PREFIX_WIDE)
                    ? {{(APB_DATA_W-1){1'b0}}, prefix_wide_reg}
                    : '0;

    // ---------------- decode ----------------
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    assign plen      = prefix_wide_reg ? PLEN_WIDE : PLEN_NARROW;
    assign count_inc = prefix_count_reg + 3'd1;
    assign len_shift = {body_remaining_reg[7:0], s_in_byte};
    assign rem_dec   = body_remaining_reg - 16'd1;

    always_comb begin
        prefix_count_next   = prefix_count_reg;
        body_remaining_next = body_remaining_reg;
        seq_pending_next    = seq_pending_reg;
        partial_unit_next   = partial_unit_reg;
        error_seen_next     = error_seen_reg;
        res_valid           = 1'b0;
        res                 = '0;
        unit                = '0;
        have_unit           = 1'b0;

        if (in_accept) begin
            if (prefix_count_reg != BODY_PHASE) begin
                body_remaining_next = len_shift;
                prefix_count_next   = count_inc;
                if (count_inc >= plen) begin
                    if (len_shift == 16'd0) begin
                        // empty string: closes on the last prefix byte
                        prefix_count_next = '0;
                        res_valid         = 1'b1;
                        res.last          = 1'b1;
                    end else begin
                        prefix_count_next = BODY_PHASE;
                    end
                end
            end else begin
                if (!error_seen_reg) begin
                    if (seq_pending_reg == SEQ_NONE) begin
                        case (s_in_byte[7:4]) inside
                            [4'h0:4'h7]: begin
                                unit      = {8'd0, s_in_byte};
                                have_unit = 1'b1;
                            end
                            4'hC, 4'hD: begin
                                partial_unit_next = {5'd0, s_in_byte[4:0], 6'd0};
                                seq_pending_next  = SEQ_ONE;
                            end
                            4'hE: begin
                                partial_unit_next = {s_in_byte[3:0], 12'd0};
                                seq_pending_next  = SEQ_TWO;
                            end
                            default: begin
                                error_seen_next = 1'b1;
                            end
                        endcase
                    end else if ((s_in_byte & CONT_MASK) != CONT_TAG) begin
                        error_seen_next  = 1'b1;
                        seq_pending_next = SEQ_NONE;
                    end else begin
                        if (seq_pending_reg == SEQ_TWO) begin
                            partial_unit_next = partial_unit_reg
                                                | {4'd0, s_in_byte[5:0], 6'd0};
                        end else begin
                            partial_unit_next = partial_unit_reg
                                                | {10'd0, s_in_byte[5:0]};
                        end
                        seq_pending_next = seq_pending_reg - 2'd1;
                        if (seq_pending_next == SEQ_NONE) begin
                            unit              = partial_unit_next;
                            have_unit         = 1'b1;
                            partial_unit_next = '0;
                        end
                    end
                end

                body_remaining_next = rem_dec;

                if (rem_dec == 16'd0) begin
                    // end of body; an open sequence counts as malformed
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    res.error = error_seen_next || (seq_pending_next != SEQ_NONE);
                    if (!res.error) begin
                        res.has_char  = have_unit;
                        res.code_unit = unit;
                    end
                    prefix_count_next = '0;
                    seq_pending_next  = SEQ_NONE;
                    partial_unit_next = '0;
                    error_seen_next   = 1'b0;
                end else if (have_unit) begin
                    res_valid     = 1'b1;
                    res.has_char  = 1'b1;
                    res.code_unit = unit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_count_reg   <= '0;
            body_remaining_reg <= '0;
            seq_pending_reg    <= SEQ_NONE;
            partial_unit_reg   <= '0;
            error_seen_reg     <= 1'b0;
        end else begin
            prefix_count_reg   <= prefix_count_next;
            body_remaining_reg <= body_remaining_next;
            seq_pending_reg    <= seq_pending_next;
            partial_unit_reg   <= partial_unit_next;
            error_seen_reg     <= error_seen_next;
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (in_accept && res_valid) begin
            m_valid_next = 1'b1;
            result_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_code_unit = result_reg.code_unit;
    assign m_has_char  = result_reg.has_char;
    assign m_last      = result_reg.last;
    assign m_error     = result_reg.error;

    // ---------------- assertions ----------------
    `MU8SD_ASSERT_IMPL(a_mid_carries_char, m_valid && !m_last, m_has_char,
        "non-final transaction without a code unit")
    `MU8SD_ASSERT_IMPL(a_error_only_final, m_valid && m_error, m_last && !m_has_char,
        "error flagged on a transaction that is not a bare final one")
    `MU8SD_ASSERT_IMPL(a_prefix_clean, prefix_count_reg != BODY_PHASE,
        seq_pending_reg == SEQ_NONE && !error_seen_reg,
        "sequence or error state left over into the length prefix")
    `MU8SD_ASSERT_NEXT(a_body_nonzero, prefix_count_reg == BODY_PHASE,
        body_remaining_reg != 16'd0 || prefix_count_reg != BODY_PHASE,
        "body phase with zero bytes remaining")

endmodule
